FILE: rtl/srg_pkg.sv
// shared types and constants for the speed ramp generator
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

    localparam int SPEED_W    = 16;
    localparam int TICK_W     = 16;
    localparam int OP_W       = 2;
    localparam int MODE_W     = 2;
    localparam int NUM_W      = SPEED_W + TICK_W;
    localparam int DIV_STEPS  = SPEED_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAMPING  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AT_SPEED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STOPPING = 2'd3;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: rtl/srg_divider.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module srg_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire srg_pkg::div_ctl_t             ctl,
    input  wire logic [srg_pkg::NUM_W-1:0]     dividend,
    input  wire logic [srg_pkg::TICK_W-1:0]    divisor,
    output logic [srg_pkg::SPEED_W-1:0]        quotient,
    output srg_pkg::div_status_t               status
);

    logic [srg_pkg::TICK_W-1:0]    rem_reg, rem_next;
    logic [srg_pkg::SPEED_W-1:0]   shift_reg, shift_next;
    logic [srg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [srg_pkg::TICK_W:0]      trial;
    logic [srg_pkg::TICK_W-1:0]    trial_diff;
    logic                          ge;

    // caller guarantees the quotient fits, so the high half is below the divisor
    assign trial      = {rem_reg, shift_reg[srg_pkg::SPEED_W-1]};
    // when the trial is not below the divisor the difference fits in TICK_W bits
    assign trial_diff = trial[srg_pkg::TICK_W-1:0] - divisor;
    assign ge         = (trial >= {1'b0, divisor});

    always_comb begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctl.start) begin
            rem_next   = dividend[srg_pkg::NUM_W-1:srg_pkg::SPEED_W];
            shift_next = dividend[srg_pkg::SPEED_W-1:0];
            cnt_next   = srg_pkg::DIV_CNT_W'(srg_pkg::DIV_STEPS);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_next   = ge ? trial_diff : trial[srg_pkg::TICK_W-1:0];
            shift_next = {shift_reg[srg_pkg::SPEED_W-2:0], ge};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == srg_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign quotient    = shift_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/speed_ramp_generator.sv
// speed ramp generator top level: command decode, sequencer, shared multiplier
`timescale 1ns / 1ps
`default_nettype none

// Linear motor speed ramp controller.
// Input words on s_*: s_tuser carries the operation (tick, start ramp, stop
// ramp), s_tdata the target speed and the ramp length in ticks.
// Each start or stop command, and each tick while ramping or stopping, gives
// one result word on m_*: commanded speed, target reached flag, motion state.
// Ticks while idle or at speed, and the unused operation code, give nothing.
// A word that needs interpolation runs one shared 16x16 multiplier twice
// (start*length, then slope*elapsed) and then a 16-step iterative divider,
// and the sequencer takes no new word until that result goes to the output
// register. A word that completes a move skips the multiplier and divider and
// goes straight to the output; a word that gives no result leaves it idle.
// s_tready is high only while the sequencer is idle; the result sits in an
// output register, so the next word is taken while a result waits. If the
// receiver stalls, the sequencer holds its finished result until the output
// register is free.
// aresetn (synchronous, active low) clears the state: idle at zero speed.

module speed_ramp_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] target_rpm, [31:16] duration_ticks
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] speed_rpm
    output logic [2:0]       m_tuser    // [0] target_reached, [2:1] motion_state
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_EVAL      = 3'd1;
    localparam logic [2:0] ST_MUL_BASE  = 3'd2;
    localparam logic [2:0] ST_MUL_STEP  = 3'd3;
    localparam logic [2:0] ST_DIV_START = 3'd4;
    localparam logic [2:0] ST_DIVIDE    = 3'd5;
    localparam logic [2:0] ST_EMIT      = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [srg_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [srg_pkg::SPEED_W-1:0]    current_reg, current_next;
    logic [srg_pkg::SPEED_W-1:0]    start_reg, start_next;
    logic [srg_pkg::SPEED_W-1:0]    goal_reg, goal_next;
    logic [srg_pkg::TICK_W-1:0]     len_reg, len_next;
    logic [srg_pkg::TICK_W-1:0]     elapsed_reg, elapsed_next;
    logic [srg_pkg::NUM_W-1:0]      acc_reg, acc_next;
    logic                           reached_reg, reached_next;

    logic                           m_valid_reg, m_valid_next;
    logic [srg_pkg::SPEED_W-1:0]    m_speed_reg, m_speed_next;
    logic                           m_reached_reg, m_reached_next;
    logic [srg_pkg::MODE_W-1:0]     m_mode_reg, m_mode_next;

    logic                           in_fire;
    logic [srg_pkg::OP_W-1:0]       op;
    logic [srg_pkg::SPEED_W-1:0]    in_target;
    logic [srg_pkg::TICK_W-1:0]     in_duration;
    logic                           rising;
    logic [srg_pkg::SPEED_W-1:0]    slope_abs;
    logic [srg_pkg::SPEED_W-1:0]    mul_a;
    logic [srg_pkg::TICK_W-1:0]     mul_b;
    logic [srg_pkg::NUM_W-1:0]      product;
    logic                           out_free;

    srg_pkg::div_ctl_t              div_ctl;
    srg_pkg::div_status_t           div_status;
    logic [srg_pkg::SPEED_W-1:0]    div_quotient;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign op          = s_tuser;
    assign in_target   = s_tdata[15:0];
    assign in_duration = s_tdata[31:16];
    assign out_free    = !m_valid_reg || m_tready;

    assign rising    = (goal_reg >= start_reg);
    assign slope_abs = rising ? (goal_reg - start_reg) : (start_reg - goal_reg);

    // one multiplier, shared by the base term and the slope term
    always_comb begin
        if (state_reg == ST_MUL_STEP) begin
            mul_a = slope_abs;
            mul_b = elapsed_reg;
        end else begin
            mul_a = start_reg;
            mul_b = len_reg;
        end
    end
    assign product = mul_a * mul_b;

    assign div_ctl.start = (state_reg == ST_DIV_START);

    srg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (acc_reg),
        .divisor  (len_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        current_next   = current_reg;
        start_next     = start_reg;
        goal_next      = goal_reg;
        len_next       = len_reg;
        elapsed_next   = elapsed_reg;
        acc_next       = acc_reg;
        reached_next   = reached_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_speed_next   = m_speed_reg;
        m_reached_next = m_reached_reg;
        m_mode_next    = m_mode_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (op == srg_pkg::OP_START || op == srg_pkg::OP_STOP) begin
                        start_next   = current_reg;
                        goal_next    = (op == srg_pkg::OP_START) ? in_target : '0;
                        len_next     = in_duration;
                        elapsed_next = '0;
                        mode_next    = (op == srg_pkg::OP_START) ? srg_pkg::MODE_RAMPING
                                                                 : srg_pkg::MODE_STOPPING;
                        state_next   = ST_EVAL;
                    end else if (op == srg_pkg::OP_TICK &&
                                 (mode_reg == srg_pkg::MODE_RAMPING ||
                                  mode_reg == srg_pkg::MODE_STOPPING)) begin
                        if (elapsed_reg < len_reg) begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                if (elapsed_reg >= len_reg) begin
                    if (mode_reg == srg_pkg::MODE_RAMPING) begin
                        current_next = goal_reg;
                        mode_next    = srg_pkg::MODE_AT_SPEED;
                        reached_next = 1'b1;
                    end else begin
                        current_next = '0;
                        mode_next    = srg_pkg::MODE_IDLE;
                        reached_next = (current_reg != '0);
                    end
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_MUL_BASE;
                end
            end
            ST_MUL_BASE: begin
                acc_next   = product;
                state_next = ST_MUL_STEP;
            end
            ST_MUL_STEP: begin
                // numerator stays between start*len and goal*len
                acc_next   = rising ? (acc_reg + product) : (acc_reg - product);
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_status.done) begin
                    current_next = div_quotient;
                    reached_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_speed_next   = current_reg;
                    m_reached_next = reached_reg;
                    m_mode_next    = mode_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= srg_pkg::MODE_IDLE;
            current_reg <= '0;
            start_reg   <= '0;
            goal_reg    <= '0;
            len_reg     <= '0;
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            current_reg <= current_next;
            start_reg   <= start_next;
            goal_reg    <= goal_next;
            len_reg     <= len_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
        end
        acc_reg       <= acc_next;
        reached_reg   <= reached_next;
        m_speed_reg   <= m_speed_next;
        m_reached_reg <= m_reached_next;
        m_mode_reg    <= m_mode_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_speed_reg;
    assign m_tuser  = {m_mode_reg, m_reached_reg};

    a_div_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide step");

    a_div_busy_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == ST_DIVIDE))
        else $error("divider running outside the divide step");

    a_idle_is_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == srg_pkg::MODE_IDLE) |-> (current_reg == '0))
        else $error("idle with nonzero speed");

    a_at_speed_on_goal: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == srg_pkg::MODE_AT_SPEED) |-> (current_reg == goal_reg))
        else $error("at speed but speed differs from goal");

    a_elapsed_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        elapsed_reg <= len_reg)
        else $error("elapsed tick count passed the ramp length");

endmodule

`default_nettype wire
